/* design/angle_bias_kalman_filter_unit_assert.svh */
// Assertion macros shared by the filter RTL.
`ifndef ANGLE_BIAS_KALMAN_FILTER_UNIT_ASSERT_SVH
`define ANGLE_BIAS_KALMAN_FILTER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define ABK_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define ABK_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ABK_ASSERT(label, clk, rstn, prop, msg)
`define ABK_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

/* design/abkf_pkg.sv */
`default_nettype none
package abkf_pkg;
    localparam int NUM_AXES_DEF = 3;
    localparam logic [31:0] Q_ANGLE_RST = 32'd16777;
    localparam logic [31:0] Q_BIAS_RST  = 32'd50332;
    localparam logic [31:0] R_MEAS_RST  = 32'd503316;
    localparam logic [1:0] REG_Q_ANGLE = 2'd0;
    localparam logic [1:0] REG_Q_BIAS  = 2'd1;
    localparam logic [1:0] REG_R_MEAS  = 2'd2;

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_MUL  = 7'b0000010,
        ST_ACC  = 7'b0000100,
        ST_DIV  = 7'b0001000,
        ST_STORE= 7'b0010000,
        ST_OUT  = 7'b0100000,
        ST_CLR  = 7'b1000000
    } state_t;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647) return 32'sh7fffffff;
        else if (v < -66'sd2147483648) return 32'sh80000000;
        else return v[31:0];
    endfunction
endpackage
`default_nettype wire

/* design/angle_bias_kalman_filter_unit.sv */
// Two-state angle and gyro-bias Kalman filter with one state set per axis.
// A step transfer on the slave stream (tuser = action, tdata = axis, measured
// angle, gyro rate, time step) runs ten multiply operations, each through a
// multiply state and an accumulate state, on one shared 33x35-bit signed
// multiplier, plus two 57-bit restoring divisions for the two gains; the
// divider gives one quotient bit per cycle. The block takes no new step until
// the result of the last one has been handed to its output register. A waiting
// result holds the next step in its output state until it is taken. A clear
// transfer zeroes all axes and gives no result; a step for an axis at or above
// NUM_AXES is dropped and gives no result. After reset the block runs the same
// clearing pass and is not ready until it is done.
`default_nettype none
`include "angle_bias_kalman_filter_unit_assert.svh"
module angle_bias_kalman_filter_unit #(
    parameter int NUM_AXES = abkf_pkg::NUM_AXES_DEF
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [95:0] s_tdata,   // axis[1:0], meas_angle[33:2], gyro_rate[65:34], time_step[89:66], zeros above
    input  wire         s_tuser,   // action
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [39:0] m_tdata,   // out_axis[1:0], filtered_angle[33:2], zeros above
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire  [1:0]  cfg_index,
    input  wire  [31:0] cfg_data
);
    localparam int AW = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;

    logic [31:0] q_ang_reg, q_bias_reg, r_meas_reg;
    logic signed [31:0] ang_mem [NUM_AXES];
    logic signed [31:0] bias_mem[NUM_AXES];
    logic signed [31:0] paa_mem [NUM_AXES];
    logic signed [31:0] pab_mem [NUM_AXES];
    logic signed [31:0] pba_mem [NUM_AXES];
    logic signed [31:0] pbb_mem [NUM_AXES];

    abkf_pkg::state_t state_reg;
    logic [3:0]  op_reg;
    logic [5:0]  cnt_reg;
    logic [AW-1:0] ax_reg;
    logic [1:0]  axis_in_reg;
    logic signed [31:0] meas_reg, rate_reg, dt_reg;
    logic signed [31:0] ang_reg, bias_reg, p00_reg, p01_reg, p10_reg, p11_reg;
    logic signed [31:0] dp11_reg, k0_reg, k1_reg, t0_reg, t1_reg;
    logic signed [32:0] y_reg;
    logic signed [32:0] mul_a;
    logic signed [34:0] mul_b;
    logic signed [65:0] prod_reg;
    logic [56:0] num_reg;
    logic [56:0] quo_reg;
    logic [33:0] den_reg;
    logic [33:0] rem_reg;
    logic        neg_reg;
    logic        sz_reg;
    logic        kidx_reg;
    logic [39:0] m_tdata_reg;
    logic        m_tvalid_reg;

    logic [65:0] mag_p;
    logic signed [65:0] msh;
    logic signed [65:0] s_sum;
    logic [34:0] rem_try;
    logic signed [65:0] qs;

    assign s_tready  = (state_reg == abkf_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    always_comb begin
        mag_p = prod_reg[65] ? (~prod_reg + 66'd1) : prod_reg;
        msh   = $signed(mag_p >> 24);
        if (prod_reg[65]) msh = -msh;
        s_sum   = 66'(p00_reg) + $signed({34'd0, r_meas_reg});
        rem_try = {rem_reg, num_reg[56]} - {1'b0, den_reg};
        qs = $signed({9'd0, quo_reg});
        if (neg_reg) qs = -qs;
    end

    // operand selection for each multiply operation
    always_comb begin
        mul_a = '0; mul_b = '0;
        unique case (op_reg)
            4'd0: begin mul_a = 33'(dt_reg); mul_b = 35'(rate_reg) - 35'(bias_reg); end
            4'd1: begin mul_a = 33'(dt_reg); mul_b = 35'(p11_reg); end
            4'd2: begin mul_a = 33'(dt_reg);
                  mul_b = 35'(dp11_reg) - 35'(p01_reg) - 35'(p10_reg)
                          + $signed({3'b0, q_ang_reg}); end
            4'd3: begin mul_a = $signed({1'b0, q_bias_reg}); mul_b = 35'(dt_reg); end
            4'd4: begin mul_a = 33'(k0_reg); mul_b = 35'(y_reg); end
            4'd5: begin mul_a = 33'(k1_reg); mul_b = 35'(y_reg); end
            4'd6: begin mul_a = 33'(k0_reg); mul_b = 35'(t0_reg); end
            4'd7: begin mul_a = 33'(k0_reg); mul_b = 35'(t1_reg); end
            4'd8: begin mul_a = 33'(k1_reg); mul_b = 35'(t0_reg); end
            4'd9: begin mul_a = 33'(k1_reg); mul_b = 35'(t1_reg); end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_ang_reg <= abkf_pkg::Q_ANGLE_RST;
            q_bias_reg <= abkf_pkg::Q_BIAS_RST;
            r_meas_reg <= abkf_pkg::R_MEAS_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                abkf_pkg::REG_Q_ANGLE: q_ang_reg <= cfg_data;
                abkf_pkg::REG_Q_BIAS:  q_bias_reg <= cfg_data;
                abkf_pkg::REG_R_MEAS:  r_meas_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= 66'(mul_a) * 66'(mul_b);
        if (!aresetn) begin
            state_reg <= abkf_pkg::ST_CLR;
            ax_reg <= '0;
            m_tvalid_reg <= 1'b0;
            op_reg <= '0;
            cnt_reg <= '0;
        end else begin
            if (m_tvalid_reg && m_tready && state_reg != abkf_pkg::ST_OUT)
                m_tvalid_reg <= 1'b0;
            unique case (state_reg)
                abkf_pkg::ST_IDLE: begin
                    if (s_tvalid && s_tready) begin
                        axis_in_reg <= s_tdata[1:0];
                        meas_reg <= s_tdata[33:2];
                        rate_reg <= s_tdata[65:34];
                        dt_reg   <= {8'd0, s_tdata[89:66]};
                        if (s_tuser) begin
                            ax_reg <= '0;
                            state_reg <= abkf_pkg::ST_CLR;
                        end else if (32'(s_tdata[1:0]) < NUM_AXES) begin
                            ax_reg   <= AW'(s_tdata[1:0]);
                            ang_reg  <= ang_mem[AW'(s_tdata[1:0])];
                            bias_reg <= bias_mem[AW'(s_tdata[1:0])];
                            p00_reg  <= paa_mem[AW'(s_tdata[1:0])];
                            p01_reg  <= pab_mem[AW'(s_tdata[1:0])];
                            p10_reg  <= pba_mem[AW'(s_tdata[1:0])];
                            p11_reg  <= pbb_mem[AW'(s_tdata[1:0])];
                            op_reg <= 4'd0;
                            state_reg <= abkf_pkg::ST_MUL;
                        end
                    end
                end
                abkf_pkg::ST_CLR: begin
                    ang_mem[ax_reg] <= '0; bias_mem[ax_reg] <= '0;
                    paa_mem[ax_reg] <= '0; pab_mem[ax_reg] <= '0;
                    pba_mem[ax_reg] <= '0; pbb_mem[ax_reg] <= '0;
                    if (32'(ax_reg) == NUM_AXES - 1) state_reg <= abkf_pkg::ST_IDLE;
                    else ax_reg <= ax_reg + AW'(1);
                end
                abkf_pkg::ST_MUL: state_reg <= abkf_pkg::ST_ACC;
                abkf_pkg::ST_ACC: begin
                    state_reg <= abkf_pkg::ST_MUL;
                    op_reg <= op_reg + 4'd1;
                    unique case (op_reg)
                        4'd0: ang_reg <= abkf_pkg::sat32(66'(ang_reg) + msh);
                        4'd1: dp11_reg <= msh[31:0];
                        4'd2: begin
                            p00_reg <= abkf_pkg::sat32(66'(p00_reg) + msh);
                            p01_reg <= abkf_pkg::sat32(66'(p01_reg) - 66'(dp11_reg));
                            p10_reg <= abkf_pkg::sat32(66'(p10_reg) - 66'(dp11_reg));
                        end
                        4'd3: begin
                            p11_reg <= abkf_pkg::sat32(66'(p11_reg) + msh);
                            kidx_reg <= 1'b0;
                            k0_reg <= '0; k1_reg <= '0;
                            state_reg <= abkf_pkg::ST_DIV;
                            cnt_reg <= '0;
                            sz_reg <= (s_sum == 66'sd0);
                            den_reg <= s_sum[65] ? 34'(-s_sum) : s_sum[33:0];
                            num_reg <= {1'b0, p00_reg[31] ? -p00_reg : p00_reg, 24'd0};
                            neg_reg <= p00_reg[31] ^ s_sum[65];
                            rem_reg <= '0; quo_reg <= '0;
                        end
                        4'd4: ang_reg <= abkf_pkg::sat32(66'(ang_reg) + msh);
                        4'd5: bias_reg <= abkf_pkg::sat32(66'(bias_reg) + msh);
                        4'd6: p00_reg <= abkf_pkg::sat32(66'(t0_reg) - msh);
                        4'd7: p01_reg <= abkf_pkg::sat32(66'(t1_reg) - msh);
                        4'd8: p10_reg <= abkf_pkg::sat32(66'(p10_reg) - msh);
                        4'd9: begin
                            p11_reg <= abkf_pkg::sat32(66'(p11_reg) - msh);
                            state_reg <= abkf_pkg::ST_STORE;
                        end
                        default: state_reg <= abkf_pkg::ST_STORE;
                    endcase
                end
                abkf_pkg::ST_DIV: begin
                    if (cnt_reg == 6'd57) begin
                        if (!sz_reg) begin
                            if (kidx_reg) k1_reg <= abkf_pkg::sat32(qs);
                            else k0_reg <= abkf_pkg::sat32(qs);
                        end
                        if (kidx_reg) begin
                            y_reg <= 33'(66'(meas_reg) - 66'(ang_reg));
                            t0_reg <= p00_reg; t1_reg <= p01_reg;
                            op_reg <= 4'd4;
                            state_reg <= abkf_pkg::ST_MUL;
                        end else begin
                            kidx_reg <= 1'b1;
                            cnt_reg <= '0;
                            num_reg <= {1'b0, p10_reg[31] ? -p10_reg : p10_reg, 24'd0};
                            neg_reg <= p10_reg[31] ^ s_sum[65];
                            rem_reg <= '0; quo_reg <= '0;
                        end
                    end else begin
                        cnt_reg <= cnt_reg + 6'd1;
                        num_reg <= {num_reg[55:0], 1'b0};
                        if (!rem_try[34]) begin
                            rem_reg <= rem_try[33:0];
                            quo_reg <= {quo_reg[55:0], 1'b1};
                        end else begin
                            rem_reg <= {rem_reg[32:0], num_reg[56]};
                            quo_reg <= {quo_reg[55:0], 1'b0};
                        end
                    end
                end
                abkf_pkg::ST_STORE: begin
                    ang_mem[ax_reg] <= ang_reg; bias_mem[ax_reg] <= bias_reg;
                    paa_mem[ax_reg] <= p00_reg; pab_mem[ax_reg] <= p01_reg;
                    pba_mem[ax_reg] <= p10_reg; pbb_mem[ax_reg] <= p11_reg;
                    state_reg <= abkf_pkg::ST_OUT;
                end
                abkf_pkg::ST_OUT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tdata_reg <= {6'd0, ang_reg, axis_in_reg};
                        m_tvalid_reg <= 1'b1;
                        state_reg <= abkf_pkg::ST_IDLE;
                    end
                end
                default: state_reg <= abkf_pkg::ST_IDLE;
            endcase
        end
    end

    `ABK_ASSERT(a_busy_not_ready, aclk, aresetn, (state_reg != abkf_pkg::ST_IDLE) |-> !s_tready, "ready while busy")
    `ABK_ASSERT(a_out_once, aclk, aresetn, (state_reg == abkf_pkg::ST_OUT) |=> m_tvalid, "result not raised")
    `ABK_ASSERT(a_out_axis, aclk, aresetn, m_tvalid |-> (32'(m_tdata[1:0]) < NUM_AXES), "bad result axis")
    `ABK_ASSERT(a_no_take_when_full, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid, "result lost")
endmodule
`default_nettype wire

/* tb/tb_angle_bias_kalman_filter_unit.sv */
`default_nettype none
module tb_angle_bias_kalman_filter_unit;

    localparam int        AXES       = abkf_pkg::NUM_AXES_DEF;
    localparam logic      ACT_STEP   = 1'b0;
    localparam logic      ACT_CLEAR  = 1'b1;
    localparam logic [1:0] REG_NONE  = 2'd3;
    localparam int        SETTLE     = 400;
    localparam longint    CYCLE_CAP  = 1500000;

    typedef struct packed {
        logic               action;
        logic [1:0]         axis;
        logic signed [31:0] meas;
        logic signed [31:0] rate;
        logic [23:0]        dt;
    } sample_t;

    typedef struct packed {
        logic [1:0]         axis;
        logic signed [31:0] angle;
    } angle_out_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    wire         s_tready;
    logic [95:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    wire         m_tvalid;
    logic        m_tready = 1'b0;
    wire  [39:0] m_tdata;
    logic        cfg_valid = 1'b0;
    wire         cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    angle_bias_kalman_filter_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    sample_t    sample_q[$];
    angle_out_t angle_q[$];
    sample_t    on_bus;
    int         errors = 0;
    int         send_idle_pct = 0;
    int         recv_stall_pct = 0;
    longint     cycles = 0;

    logic [31:0]        q_angle_sh, q_bias_sh, r_meas_sh;
    logic signed [31:0] ang_st[AXES], bias_st[AXES];
    logic signed [31:0] paa[AXES], pab[AXES], pba[AXES], pbb[AXES];

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // Product of magnitudes, shifted, then signed: truncates toward zero.
    function automatic longint scaled_mul(longint a, longint b, int n);
        longint unsigned ma, mb, p;
        ma = a < 0 ? -a : a;
        mb = b < 0 ? -b : b;
        p = (ma * mb) >> n;
        return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
    endfunction

    task automatic clear_filters();
        for (int i = 0; i < AXES; i++) begin
            ang_st[i] = 0; bias_st[i] = 0;
            paa[i] = 0; pab[i] = 0; pba[i] = 0; pbb[i] = 0;
        end
    endtask

    task automatic kalman_update(sample_t it);
        longint ang, bias, p00, p01, p10, p11, dt, dp11, inner, s, k0, k1, y, t0, t1;
        int a;
        angle_out_t r;
        if (it.action == ACT_CLEAR) begin
            clear_filters();
            return;
        end
        if (it.axis >= AXES) return;
        a = int'(it.axis);
        dt = longint'(it.dt);
        ang = longint'(ang_st[a]); bias = longint'(bias_st[a]);
        p00 = longint'(paa[a]); p01 = longint'(pab[a]);
        p10 = longint'(pba[a]); p11 = longint'(pbb[a]);

        ang = clamp32(ang + scaled_mul(dt, longint'(it.rate) - bias, 24));
        dp11 = scaled_mul(dt, p11, 24);
        inner = dp11 - p01 - p10 + longint'(q_angle_sh);
        p00 = clamp32(p00 + scaled_mul(dt, inner, 24));
        p01 = clamp32(p01 - dp11);
        p10 = clamp32(p10 - dp11);
        p11 = clamp32(p11 + scaled_mul(longint'(q_bias_sh), dt, 24));

        s = p00 + longint'(r_meas_sh);
        k0 = 0; k1 = 0;
        if (s != 0) begin
            k0 = clamp32((p00 * 64'sd16777216) / s);
            k1 = clamp32((p10 * 64'sd16777216) / s);
        end

        y = longint'(it.meas) - ang;
        ang = clamp32(ang + scaled_mul(k0, y, 24));
        bias = clamp32(bias + scaled_mul(k1, y, 24));
        t0 = p00; t1 = p01;
        p00 = clamp32(p00 - scaled_mul(k0, t0, 24));
        p01 = clamp32(p01 - scaled_mul(k0, t1, 24));
        p10 = clamp32(p10 - scaled_mul(k1, t0, 24));
        p11 = clamp32(p11 - scaled_mul(k1, t1, 24));

        ang_st[a] = 32'(ang); bias_st[a] = 32'(bias);
        paa[a] = 32'(p00); pab[a] = 32'(p01); pba[a] = 32'(p10); pbb[a] = 32'(p11);
        r.axis = it.axis;
        r.angle = 32'(ang);
        angle_q.push_back(r);
    endtask

    task automatic report(string field, logic [31:0] got, logic [31:0] want);
        errors++;
        $display("mismatch %s: got %h, expected %h", field, got, want);
    endtask

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("FAIL angle_bias_kalman_filter_unit");
            $finish;
        end
    end

    // Stimulus driver: predicts on each accepted transfer, then offers the next item.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) kalman_update(on_bus);
            if (!s_tvalid || s_tready) begin
                if (sample_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    on_bus = sample_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser <= on_bus.action;
                    s_tdata <= {6'd0, on_bus.dt, on_bus.rate, on_bus.meas, on_bus.axis};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor.
    always @(posedge aclk) begin
        angle_out_t w;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (angle_q.size() == 0) begin
                    report("unexpected transfer", m_tdata[33:2], 32'h0);
                end else begin
                    w = angle_q.pop_front();
                    if (m_tdata[1:0] !== w.axis)
                        report("out_axis", 32'(m_tdata[1:0]), 32'(w.axis));
                    if (m_tdata[33:2] !== w.angle)
                        report("filtered_angle", m_tdata[33:2], w.angle);
                end
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            abkf_pkg::REG_Q_ANGLE: q_angle_sh = val;
            abkf_pkg::REG_Q_BIAS:  q_bias_sh = val;
            abkf_pkg::REG_R_MEAS:  r_meas_sh = val;
            default: ;
        endcase
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (sample_q.size() != 0 || s_tvalid || angle_q.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic push_step(logic [1:0] ax, logic [31:0] m, logic [31:0] r, logic [23:0] d);
        sample_t it;
        it.action = ACT_STEP; it.axis = ax; it.meas = m; it.rate = r; it.dt = d;
        sample_q.push_back(it);
    endtask

    task automatic push_clear();
        sample_t it;
        it.action = ACT_CLEAR;
        it.axis = 2'($urandom);
        it.meas = $urandom;
        it.rate = $urandom;
        it.dt = 24'($urandom);
        sample_q.push_back(it);
    endtask

    task automatic push_random();
        int pick;
        logic [1:0] ax;
        pick = $urandom_range(99);
        ax = 2'($urandom_range(AXES - 1));
        if (pick < 3) push_clear();
        else if (pick < 6) push_step(2'd3, $urandom, $urandom, 24'($urandom));
        else if (pick < 12) push_step(2'($urandom), $urandom, $urandom, 24'($urandom));
        else push_step(ax, $urandom_range(32'h0168_0000) - 32'h00B4_0000,
                       $urandom_range(32'h03E8_0000) - 32'h01F4_0000,
                       24'($urandom_range(400000, 1000)));
    endtask

    initial begin
        q_angle_sh = abkf_pkg::Q_ANGLE_RST;
        q_bias_sh = abkf_pkg::Q_BIAS_RST;
        r_meas_sh = abkf_pkg::R_MEAS_RST;
        clear_filters();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        push_step(2'd0, 32'h0001_0000, 32'h0000_8000, 24'd0);
        push_step(2'd0, 32'h7fff_ffff, 32'h7fff_ffff, 24'hffffff);
        push_step(2'd0, 32'h8000_0000, 32'h8000_0000, 24'hffffff);
        push_step(2'd1, 32'h7fff_ffff, 32'h8000_0000, 24'h000001);
        push_step(2'd2, 32'h8000_0000, 32'h7fff_ffff, 24'h800000);
        push_step(2'd1, 32'h0000_0000, 32'hffff_ffff, 24'h010000);
        push_step(2'd3, 32'h1234_5678, 32'h0000_1000, 24'h001000);
        push_step(2'd2, 32'h0010_0000, 32'h0000_0000, 24'h004000);
        push_clear();
        push_step(2'd2, 32'hfff0_0000, 32'h0001_0000, 24'h004000);
        push_step(2'd0, 32'h0020_0000, 32'hffff_0000, 24'h004000);
        drain();

        // All noise terms zero after a clear leave the innovation variance at zero.
        write_reg(abkf_pkg::REG_Q_ANGLE, 32'h0);
        write_reg(abkf_pkg::REG_Q_BIAS, 32'h0);
        write_reg(abkf_pkg::REG_R_MEAS, 32'h0);
        write_reg(REG_NONE, 32'hffff_ffff);
        push_clear();
        push_step(2'd0, 32'h0100_0000, 32'h0001_0000, 24'hffffff);
        push_step(2'd1, 32'h8000_0000, 32'h7fff_ffff, 24'h000000);
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin write_reg(abkf_pkg::REG_Q_ANGLE, abkf_pkg::Q_ANGLE_RST);
                         write_reg(abkf_pkg::REG_Q_BIAS, abkf_pkg::Q_BIAS_RST);
                         write_reg(abkf_pkg::REG_R_MEAS, abkf_pkg::R_MEAS_RST); end
                1: begin write_reg(abkf_pkg::REG_Q_ANGLE, 32'hffff_ffff);
                         write_reg(abkf_pkg::REG_Q_BIAS, 32'hffff_ffff);
                         write_reg(abkf_pkg::REG_R_MEAS, 32'hffff_ffff); end
                3: begin write_reg(abkf_pkg::REG_Q_ANGLE, 32'h0);
                         write_reg(abkf_pkg::REG_Q_BIAS, 32'h0);
                         write_reg(abkf_pkg::REG_R_MEAS, 32'h0); end
                default: begin
                    write_reg(abkf_pkg::REG_Q_ANGLE, $urandom_range(32'h0010_0000));
                    write_reg(abkf_pkg::REG_Q_BIAS, $urandom_range(32'h0010_0000));
                    write_reg(abkf_pkg::REG_R_MEAS, $urandom_range(32'h0100_0000));
                end
            endcase
            write_reg(REG_NONE, $urandom);
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
                default: begin send_idle_pct = 30; recv_stall_pct = 30; end
            endcase
            for (int n = 0; n < 238; n++) push_random();
            drain();
        end

        if (errors == 0) begin
            $display("PASS angle_bias_kalman_filter_unit");
        end else begin
            $display("FAIL angle_bias_kalman_filter_unit");
        end
        $finish;
    end
endmodule
`default_nettype wire

/* files.f */
+incdir+design
design/abkf_pkg.sv
design/angle_bias_kalman_filter_unit.sv
tb/tb_angle_bias_kalman_filter_unit.sv
